### sv/etb_pkg.sv
// Package: shared types and constants for the elimination tree builder.
`timescale 1ns / 1ps

package etb_pkg;

  localparam int unsigned NODE_W        = 10;
  localparam int unsigned SIZE_W        = 11;
  localparam int unsigned EPOCH_W       = 4;
  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned NODE_SPAN     = 1 << NODE_W;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(1024);
  localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_INIT = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

  // One ancestor store word: epoch tag plus ancestor node.
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [NODE_W-1:0]  anc;
  } anc_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_G,
    ST_H,
    ST_LINK,
    ST_DONE
  } etb_state_t;

endpackage

### sv/etb_anc_mem.sv
// Ancestor store: one write port, one read port, registered read with write bypass.
`timescale 1ns / 1ps

module etb_anc_mem #(
  parameter int unsigned DEPTH = etb_pkg::MAX_NODES_DEF,
  parameter int unsigned AW    = $clog2(etb_pkg::MAX_NODES_DEF)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  etb_pkg::anc_word_t  wr_data,
  output etb_pkg::anc_word_t  rd_data
);
  import etb_pkg::*;

  anc_word_t mem [DEPTH];
  anc_word_t rd_q;
  anc_word_t fwd_data;
  logic      fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  // same-cycle read of the entry being written returns the new word
  assign rd_data = fwd_hit ? fwd_data : rd_q;

endmodule

### sv/elimination_tree_builder_top.sv
// Top level: elimination tree builder with union-find walk over the ancestor store.
`timescale 1ns / 1ps

//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  in       | input     | in_valid / in_stall  | new_matrix, row_index, column_index
//  out      | output    | out_valid / out_stall| link_made, child_node, parent_node,
//           |           |                      | entry_ignored
//  cfg      | input     | cfg_valid / cfg_ready| cfg_data (matrix_size)
//
// One request at a time. An ignored entry skips the walk: ST_START goes straight to ST_DONE.
// An entry below the diagonal passes ST_START and ST_WALK, then ST_G and ST_H for each
// path-halving step, and ends in ST_LINK and ST_DONE; each step is two dependent reads of
// the registered ancestor store. The walk ends at a root or on the range or the step bound.
// After reset a clearing pass over min(MAX_NODES,1024) entries tags every entry stale;
// no request is taken during it, configuration writes are.
// A new_matrix request bumps the epoch; every 15th one reruns that clearing pass.
// The result register lets a finished result wait under out_stall while the block idles.

module elimination_tree_builder_top #(
  parameter int unsigned MAX_NODES = etb_pkg::MAX_NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        new_matrix,
  input  logic [etb_pkg::NODE_W-1:0]  row_index,
  input  logic [etb_pkg::NODE_W-1:0]  column_index,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        link_made,
  output logic [etb_pkg::NODE_W-1:0]  child_node,
  output logic [etb_pkg::NODE_W-1:0]  parent_node,
  output logic                        entry_ignored,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [etb_pkg::SIZE_W-1:0]  cfg_data
);
  import etb_pkg::*;

  // nodes never exceed the 10-bit index range, so the store stops there
  localparam int unsigned DEPTH = (MAX_NODES < NODE_SPAN) ? MAX_NODES : NODE_SPAN;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  etb_state_t state, state_next;

  logic [SIZE_W-1:0]  matrix_size;
  logic [SIZE_W-1:0]  n_eff;
  logic [EPOCH_W-1:0] epoch;
  logic [AW-1:0]      clr_addr;
  logic               item_pending;
  logic [NODE_W-1:0]  row_j;
  logic [NODE_W-1:0]  col_i;
  logic [NODE_W-1:0]  node_x;
  logic [NODE_W-1:0]  node_gq;
  logic [SIZE_W-1:0]  steps;
  logic [SIZE_W-1:0]  steps_inc;
  logic               res_link;
  logic               res_ign;
  logic [NODE_W-1:0]  res_child;
  logic [NODE_W-1:0]  res_parent;

  // memory request
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  anc_word_t          wr_data;
  anc_word_t          rd_data;

  logic               in_accept;
  logic               out_free;
  logic               ignore_hit;
  logic [NODE_W-1:0]  node_self;
  logic [NODE_W-1:0]  node_g;
  logic               g_stop;
  logic               x_live;
  logic               h_go;
  logic               link_ok;

  etb_anc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_anc_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // effective order, saturated to MAX_NODES
  assign n_eff = (32'(matrix_size) > MAX_NODES) ? SIZE_W'(MAX_NODES) : matrix_size;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // below-diagonal test: i < j < n
  assign ignore_hit = (col_i >= row_j) || ({1'b0, row_j} >= n_eff);

  // the word in rd_data belongs to the node read last cycle: x in ST_G, g in ST_H;
  // stale epoch means unlinked, so that node is its own ancestor
  assign node_self = (state == ST_H) ? node_gq : node_x;
  assign node_g    = (rd_data.tag == epoch) ? rd_data.anc : node_self;
  assign g_stop    = (node_g == node_x) || ({1'b0, node_g} >= n_eff);
  assign x_live    = ({1'b0, node_x} < n_eff) && (steps < n_eff);
  assign steps_inc = steps + SIZE_W'(1);
  // in ST_H, node_g holds h: the ancestor of the saved g (node_x register still x)
  assign h_go      = ({1'b0, node_g} < n_eff) && (steps_inc < n_eff);
  assign link_ok   = ({1'b0, node_x} < n_eff) && (node_x != row_j);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = item_pending ? ST_START : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (new_matrix && (epoch == EPOCH_LAST)) ? ST_CLEAR : ST_START;
        end
      end
      ST_START: state_next = ignore_hit ? ST_DONE : ST_WALK;
      ST_WALK:  state_next = x_live ? ST_G : ST_LINK;
      ST_G:     state_next = g_stop ? ST_LINK : ST_H;
      ST_H:     state_next = h_go ? ST_G : ST_LINK;
      ST_LINK:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  // memory control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = node_x[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = node_x[AW-1:0];
    wr_data = '{tag: epoch, anc: node_g};
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '{tag: EPOCH_NONE, anc: '0};
      end
      ST_WALK: begin
        rd_en = x_live;
      end
      ST_G: begin
        rd_en   = !g_stop;
        rd_addr = node_g[AW-1:0];
      end
      ST_H: begin
        // halve the path: x points at h, then read h for the next step
        wr_en   = 1'b1;
        rd_en   = h_go;
        rd_addr = node_g[AW-1:0];
      end
      ST_LINK: begin
        wr_en   = link_ok;
        wr_data = '{tag: epoch, anc: row_j};
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      epoch        <= EPOCH_INIT;
      item_pending <= 1'b0;
      matrix_size  <= SIZE_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        matrix_size <= cfg_data;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            clr_addr <= '0;
            epoch    <= EPOCH_INIT;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            item_pending <= 1'b1;
            if (new_matrix && (epoch != EPOCH_LAST)) begin
              epoch <= epoch + EPOCH_W'(1);
            end
          end
        end
        ST_START: item_pending <= 1'b0;
        default: ;
      endcase
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          row_j    <= row_index;
          col_i    <= column_index;
        end
      end
      ST_START: begin
        node_x     <= col_i;
        steps      <= '0;
        res_link   <= 1'b0;
        res_ign    <= ignore_hit;
        res_child  <= '0;
        res_parent <= '0;
      end
      ST_G: begin
        node_gq <= node_g;
      end
      ST_H: begin
        node_x <= node_g;
        steps  <= steps_inc;
      end
      ST_LINK: begin
        res_link   <= link_ok;
        res_child  <= link_ok ? node_x : '0;
        res_parent <= link_ok ? row_j : '0;
      end
      ST_DONE: begin
        if (out_free) begin
          link_made     <= res_link;
          child_node    <= res_child;
          parent_node   <= res_parent;
          entry_ignored <= res_ign;
        end
      end
      default: ;
    endcase
  end

  // ST_G keeps g in node_gq: in ST_H an unlinked g resolves to g itself.

endmodule
